// ----- sv/assert_macros.svh -----
// Assertion macros shared by the cache RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lkvc_pkg.sv -----
// Shared constants and controller/datapath interface types for the LRU cache.
// No dependencies.
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W  = 5;
    localparam int OUT_W  = 32;

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_ENTRIES);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic             start;     // latch the accepted request
        logic             scan_rd;   // read entry scan_idx this cycle
        logic [IDX_W-1:0] scan_idx;
        logic             update;    // apply the request, load the result
    } lkvc_cmd_t;

    typedef struct packed {
        logic out_free;              // result register can take a word
    } lkvc_stat_t;

endpackage

// ----- sv/lru_key_value_cache_unit.sv -----
// Top level of the LRU key/value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_ctrl, lkvc_datapath (and lkvc_ram below it).
//
// Fully associative key/value cache of 16 entries with least-recently-used
// replacement. Each input word is a request: s_tuser selects get (0) or put (1),
// s_tdata carries the key and the value. Every request gives exactly one result
// word: m_tuser is the hit flag (key present before the request), m_tdata is the
// stored value on a get hit, all ones on a get miss, and zero for any put. A put
// of a new key into a full cache first evicts the least recent entry. The cfg
// channel sets the capacity; 0 acts as 1, values above 16 act as 16, and
// lowering it below the current fill evicts one entry per later insertion
// rather than at the write. Write it only while no request is in flight.
// One request is handled at a time. After the accepting edge the controller
// streams all 16 entries through the key RAM's single read port and compares
// them (the compare works on the registered read data), then loads the result
// register in its update state and returns to idle; no new request is taken
// before that. The update waits while a previous result word is still held by
// m_tready low. A new request is accepted while the last result waits to be
// taken.
module lru_key_value_cache_unit
    import lkvc_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [KEY_BITS+VALUE_BITS-1:0] s_tdata,  // [31:0] lookup_key, [63:32] store_value
    input  logic                           s_tuser,  // [0] op
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata,  // [31:0] read_value
    output logic                           m_tuser,  // [0] hit
    // capacity register write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CAP_W-1:0]               cfg_data
);
    lkvc_cmd_t  cmd;
    lkvc_stat_t stat;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lkvc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

// ----- sv/lkvc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkvc_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_W-1:0]          wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [DATA_W-1:0]          rdata
);
    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- sv/lkvc_ctrl.sv -----
// Request sequencer: accept, scan all entries, apply update.
// Depends on lkvc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  lkvc_stat_t stat,
    output lkvc_cmd_t  cmd
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.scan_idx  = scan_cnt_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start     = 1'b1;
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // last cycle only compares the data read for the final entry
                cmd.scan_rd   = (scan_cnt_reg != MAX_CNT);
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == MAX_CNT) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (stat.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    `ASSERT_IMPLY(a_scan_bound, aclk, aresetn, state_reg == ST_SCAN, scan_cnt_reg <= MAX_CNT, "scan counter overran")
    `ASSERT_NEXT(a_accept_scans, aclk, aresetn, (state_reg == ST_IDLE) && s_tvalid, state_reg == ST_SCAN, "accepted word did not start a scan")
endmodule

// ----- sv/lkvc_datapath.sv -----
// Entry storage, key match, LRU rank bookkeeping and result register.
// Depends on lkvc_pkg, lkvc_ram and assert_macros.svh.
`include "assert_macros.svh"
module lkvc_datapath
    import lkvc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lkvc_cmd_t                 cmd,
    output lkvc_stat_t                stat,
    input  logic [KEY_BITS+VALUE_BITS-1:0] s_tdata,
    input  logic                      s_tuser,
    input  logic                      cfg_valid,
    input  logic [CAP_W-1:0]          cfg_data,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_W-1:0]          m_tdata,
    output logic                      m_tuser
);
    // request latch
    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // per-entry state
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]      rank_reg [MAX_ENTRIES];
    logic [RANK_W-1:0]      rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CAP_W-1:0]       cap_reg;

    // scan pipeline
    logic                   live_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [VALUE_BITS-1:0]  hit_val_reg, hit_val_next;

    // result register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]       m_data_reg, m_data_next;
    logic                   m_hit_reg, m_hit_next;

    // RAM ports
    logic [KEY_BITS-1:0]    key_rdata;
    logic [VALUE_BITS-1:0]  val_rdata;
    logic                   key_we, val_we;
    logic [IDX_W-1:0]       wr_idx;

    // update helpers
    logic [CNT_W-1:0]       cap_eff;
    logic                   need_evict;
    logic [RANK_W-1:0]      lru_rank;
    logic [RANK_W-1:0]      hit_rank;
    logic [MAX_ENTRIES-1:0] evict_mask, kept;
    logic [IDX_W-1:0]       free_idx;

    lkvc_ram #(.DATA_W(KEY_BITS), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (wr_idx),
        .wdata (key_reg),
        .re    (cmd.scan_rd),
        .raddr (cmd.scan_idx),
        .rdata (key_rdata)
    );

    lkvc_ram #(.DATA_W(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (wr_idx),
        .wdata (val_reg),
        .re    (cmd.scan_rd),
        .raddr (cmd.scan_idx),
        .rdata (val_rdata)
    );

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_hit_reg;

    // zero acts as one, anything above the store size saturates
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (CNT_W'(cap_reg) > MAX_CNT) begin
            cap_eff = MAX_CNT;
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    // match compare, one entry behind the RAM address
    always_comb begin
        found_next   = found_reg;
        hit_idx_next = hit_idx_reg;
        hit_val_next = hit_val_reg;
        if (cmd.start) begin
            found_next = 1'b0;
        end else if (live_reg && valid_reg[rd_idx_reg] && !found_reg
                     && key_rdata == key_reg) begin
            found_next   = 1'b1;
            hit_idx_next = rd_idx_reg;
            hit_val_next = val_rdata;
        end
    end

    // eviction victim: valid ranks are a permutation of 0..used-1
    always_comb begin
        need_evict = (used_reg >= cap_eff) || (used_reg >= MAX_CNT);
        lru_rank   = RANK_W'(used_reg - CNT_W'(1));
        hit_rank   = rank_reg[hit_idx_reg];
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            evict_mask[i] = need_evict && valid_reg[i] && (rank_reg[i] == lru_rank);
        end
        kept     = valid_reg & ~evict_mask;
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!kept[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        valid_next    = valid_reg;
        rank_next     = rank_reg;
        used_next     = used_reg;
        key_we        = 1'b0;
        val_we        = 1'b0;
        wr_idx        = hit_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_hit_next    = m_hit_reg;
        if (cmd.update) begin
            m_tvalid_next = 1'b1;
            m_hit_next    = found_reg;
            if (found_reg) begin
                // move to front; more recent entries age by one
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (valid_reg[i] && rank_reg[i] < hit_rank) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                rank_next[hit_idx_reg] = '0;
                if (op_reg == OP_PUT) begin
                    val_we      = 1'b1;
                    m_data_next = '0;
                end else begin
                    m_data_next = OUT_W'(hit_val_reg);
                end
            end else if (op_reg == OP_PUT) begin
                // insert: drop the victim if full, age the rest, fill first hole
                m_data_next = '0;
                key_we      = 1'b1;
                val_we      = 1'b1;
                wr_idx      = free_idx;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (kept[i]) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end else if (evict_mask[i]) begin
                        rank_next[i] = '0;
                    end
                end
                valid_next           = kept;
                valid_next[free_idx] = 1'b1;
                rank_next[free_idx]  = '0;
                used_next = used_reg - CNT_W'(need_evict) + CNT_W'(1);
            end else begin
                m_data_next = '1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            used_reg     <= '0;
            cap_reg      <= CAP_RESET;
            live_reg     <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg    <= valid_next;
            used_reg     <= used_next;
            live_reg     <= cmd.scan_rd;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            rank_reg     <= rank_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg  <= cmd.scan_idx;
        hit_idx_reg <= hit_idx_next;
        hit_val_reg <= hit_val_next;
        m_data_reg  <= m_data_next;
        m_hit_reg   <= m_hit_next;
        if (cmd.start) begin
            op_reg  <= s_tuser;
            key_reg <= s_tdata[KEY_BITS-1:0];
            val_reg <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
    end

    `ASSERT_ALWAYS(a_used_count, aclk, aresetn, $countones(valid_reg) == int'(used_reg), "valid bits disagree with fill count")
    `ASSERT_ALWAYS(a_used_bound, aclk, aresetn, used_reg <= MAX_CNT, "fill count above store size")
    `ASSERT_IMPLY(a_update_free, aclk, aresetn, cmd.update, stat.out_free, "result loaded over a pending word")
endmodule
